[design/tea_pkg.sv]
// Shared types, constants and round function for the TEA block cipher.
`timescale 1ns / 1ps

package tea_pkg;

    // Round count and pipeline depth (two half-round stages per round)
    localparam int ROUNDS = 32;
    localparam int STAGES = 2 * ROUNDS;

    // Golden-ratio sum increment
    localparam logic [31:0] DELTA = 32'h9E3779B9;

    // Key register indexes on the configuration port
    localparam logic [1:0] REG_KEY_0 = 2'd0;
    localparam logic [1:0] REG_KEY_1 = 2'd1;
    localparam logic [1:0] REG_KEY_2 = 2'd2;
    localparam logic [1:0] REG_KEY_3 = 2'd3;

    // Operation codes carried in the mode field
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Input block
    typedef struct packed {
        logic        mode;
        logic [31:0] word_left;
        logic [31:0] word_right;
    } tea_in_t;

    // Result block
    typedef struct packed {
        logic [31:0] out_left;
        logic [31:0] out_right;
    } tea_out_t;

    // Block as it travels down the pipeline
    typedef struct packed {
        logic        mode;
        logic [31:0] left;
        logic [31:0] right;
    } tea_stage_t;

    // 128-bit key
    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } tea_key_t;

    // One TEA mixing term, all sums wrap at 32 bits
    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = (x << 4) + ka;
        b = x + sum;
        c = (x >> 5) + kb;
        return a ^ b ^ c;
    endfunction

endpackage

[design/tea_key_regs.sv]
// Key register bank written through the configuration port.
`timescale 1ns / 1ps

module tea_key_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output tea_pkg::tea_key_t key
);

    tea_pkg::tea_key_t key_reg;
    tea_pkg::tea_key_t key_next;

    // Register decode
    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tea_pkg::REG_KEY_0: key_next.k0 = cfg_data;
                tea_pkg::REG_KEY_1: key_next.k1 = cfg_data;
                tea_pkg::REG_KEY_2: key_next.k2 = cfg_data;
                tea_pkg::REG_KEY_3: key_next.k3 = cfg_data;
                default:            key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

[design/tea_stage.sv]
// One half-round pipeline stage: one mixing term added to or taken from one half.
`timescale 1ns / 1ps

module tea_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                phase,
    input  logic [31:0]         sum_enc,
    input  logic [31:0]         sum_dec,
    input  tea_pkg::tea_key_t   key,
    input  logic                valid_in,
    input  tea_pkg::tea_stage_t data_in,
    output logic                valid_out,
    output tea_pkg::tea_stage_t data_out
);

    logic                valid_reg;
    logic                valid_next;
    tea_pkg::tea_stage_t data_reg;
    tea_pkg::tea_stage_t data_next;

    logic        x_is_left;
    logic        decrypt;
    logic [31:0] x;
    logic [31:0] sum;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] term;
    logic [31:0] target;
    logic [31:0] result;

    // Encrypt: first half-round updates left from right, second right from left.
    // Decrypt runs the other way round and subtracts.
    always_comb
    begin
        decrypt   = (data_in.mode == tea_pkg::MODE_DECRYPT);
        x_is_left = decrypt ^ phase;
        x         = x_is_left ? data_in.left  : data_in.right;
        target    = x_is_left ? data_in.right : data_in.left;
        ka        = x_is_left ? key.k2 : key.k0;
        kb        = x_is_left ? key.k3 : key.k1;
        sum       = decrypt ? sum_dec : sum_enc;
        term      = tea_pkg::tea_mix(x, sum, ka, kb);
        result    = decrypt ? (target - term) : (target + term);

        data_next      = data_in;
        if (x_is_left)
        begin
            data_next.right = result;
        end
        else
        begin
            data_next.left = result;
        end
    end

    // Stage register, advances with the pipeline enable
    always_comb
    begin
        valid_next = en ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

[design/tea_block_cipher.sv]
// Top level of the pipelined TEA block cipher.
//
//   channel   direction  handshake             payload
//   blk       in         blk_valid/blk_ready   tea_in_t  (mode, word_left, word_right)
//   res       out        res_valid/res_ready   tea_out_t (out_left, out_right)
//   cfg       in         cfg_we                cfg_index, cfg_data (key words 0..3)
//
// One block per cycle while the result side does not stall; a block passes
// through one half-round per stage and then the result register.
// Reset clears the stage valid bits, the result valid bit and the key words.
// The pipeline moves unless the last stage holds a block and the result
// register is full and not taken; while the last stage is empty the pipeline
// keeps moving, so only the gap in front of a waiting result closes up.
`timescale 1ns / 1ps

module tea_block_cipher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  tea_pkg::tea_in_t  blk_data,
    output logic              res_valid,
    input  logic              res_ready,
    output tea_pkg::tea_out_t res_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    tea_pkg::tea_key_t   key;
    logic                pipe_en;
    logic [tea_pkg::STAGES:0] stage_valid;
    tea_pkg::tea_stage_t stage_data [tea_pkg::STAGES+1];

    logic                res_valid_reg;
    logic                res_valid_next;
    tea_pkg::tea_out_t   res_data_reg;
    logic                res_load;

    // Key words
    tea_key_regs u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // Pipeline entry
    assign stage_valid[0]      = blk_valid;
    assign stage_data[0].mode  = blk_data.mode;
    assign stage_data[0].left  = blk_data.word_left;
    assign stage_data[0].right = blk_data.word_right;

    // Half-round stages with their fixed round sums
    for (genvar s = 0; s < tea_pkg::STAGES; s++)
    begin : g_stage
        localparam int          RND     = s / 2;
        localparam logic        PHASE   = 1'(s % 2);
        localparam logic [31:0] SUM_ENC = 32'(tea_pkg::DELTA * 32'(RND + 1));
        localparam logic [31:0] SUM_DEC = 32'(tea_pkg::DELTA * 32'(tea_pkg::ROUNDS - RND));

        tea_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .phase     (PHASE),
            .sum_enc   (SUM_ENC),
            .sum_dec   (SUM_DEC),
            .key       (key),
            .valid_in  (stage_valid[s]),
            .data_in   (stage_data[s]),
            .valid_out (stage_valid[s+1]),
            .data_out  (stage_data[s+1])
        );
    end

    // Result register takes a block when empty or when its block is taken
    assign res_load  = !res_valid_reg || res_ready;
    assign pipe_en   = !stage_valid[tea_pkg::STAGES] || res_load;
    assign blk_ready = pipe_en;

    always_comb
    begin
        res_valid_next = res_load ? stage_valid[tea_pkg::STAGES] : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && stage_valid[tea_pkg::STAGES])
        begin
            res_data_reg.out_left  <= stage_data[tea_pkg::STAGES].left;
            res_data_reg.out_right <= stage_data[tea_pkg::STAGES].right;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

`ifndef NO_ASSERTIONS
    // A full result register that is not taken blocks a finished block and the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[tea_pkg::STAGES] && res_valid_reg && !res_ready) |-> !blk_ready)
        else $error("input taken while the pipeline is stalled");

    // An accepted block sits in the first stage in the next cycle
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_valid && blk_ready) |=> stage_valid[1])
        else $error("accepted block missing from first stage");

    // A stall freezes every stage valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> (stage_valid[tea_pkg::STAGES:1] == $past(stage_valid[tea_pkg::STAGES:1])))
        else $error("pipeline moved during a stall");

    // A new result only comes from a valid last stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(stage_valid[tea_pkg::STAGES]))
        else $error("result appeared without a finished block");
`endif

endmodule
